// File: sv/assert_macros.svh
// Assertion helpers used by the filter unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property holds in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Property holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: sv/skf_pkg.sv
`default_nettype none
package skf_pkg;

  // Default word format: Q4.28 in 32 bits
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 28;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PROCESS_NOISE     = 2'd0;
  localparam cfg_idx_t REG_MEASUREMENT_NOISE = 2'd1;
  localparam cfg_idx_t REG_INITIAL_ESTIMATE  = 2'd2;
  localparam cfg_idx_t REG_INITIAL_VARIANCE  = 2'd3;

  // Reset values of the noise registers (about 1e-5 and 0.01)
  localparam int PROCESS_NOISE_RST     = 2684;
  localparam int MEASUREMENT_NOISE_RST = 2684355;

  // Slice of the multiplier operand consumed per cycle
  localparam int MUL_CHUNK_W = 16;

endpackage
`default_nettype wire

// File: sv/skf_meas_if.sv
`default_nettype none
interface skf_meas_if #(
  parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] measurement;
  logic                  restart;

  modport source (output valid, output measurement, output restart, input ready);
  modport sink   (input valid, input measurement, input restart, output ready);
endinterface
`default_nettype wire

// File: sv/skf_res_if.sv
`default_nettype none
interface skf_res_if #(
  parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] estimate;
  logic [DATA_WIDTH-2:0] error_variance;
  logic [FRAC_BITS:0]    gain;

  modport source (output valid, output estimate, output error_variance, output gain,
                  input ready);
  modport sink   (input valid, input estimate, input error_variance, input gain,
                  output ready);
endinterface
`default_nettype wire

// File: sv/skf_cfg_if.sv
`default_nettype none
interface skf_cfg_if #(
  parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
);
  import skf_pkg::*;

  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [DATA_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: sv/scalar_kalman_filter_unit.sv
// Measurements (Q4.28 by default) are taken only in the idle state, so an update
// ends before the next is accepted; the restoring gain divider (one quotient bit a cycle)
// and the shared 16-bit-slice multiplier do the work.
// A pending result does not block the next measurement transaction; that update
// holds in its last step until the result register is free.
// Reset (synchronous, rst high) loads default noise, estimate 0 and variance 1.0.
`default_nettype none
`include "assert_macros.svh"
module scalar_kalman_filter_unit #(
  parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  skf_meas_if.sink  meas,
  skf_res_if.source result,
  skf_cfg_if.sink   cfg
);
  import skf_pkg::*;

  localparam int DW     = DATA_WIDTH;
  localparam int VW     = DATA_WIDTH - 1;
  localparam int GW     = FRAC_BITS + 1;
  localparam int NCHUNK = (GW + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
  localparam int BW     = NCHUNK * MUL_CHUNK_W;
  localparam int AW     = DW + BW;
  localparam int CW     = $clog2(FRAC_BITS + 1);

  localparam logic [VW-1:0] VAR_MAX = '1;
  localparam logic [GW-1:0] ONE_G   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [AW-1:0] HALF    = {{(AW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRIOR = 3'd1;
  localparam logic [2:0] S_DEN   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_GSAT  = 3'd4;
  localparam logic [2:0] S_MULE  = 3'd5;
  localparam logic [2:0] S_EST   = 3'd6;
  localparam logic [2:0] S_MULV  = 3'd7;

  // Configuration registers
  logic [VW-1:0] q_noise;
  logic [VW-1:0] r_noise;
  logic [DW-1:0] init_est;
  logic [VW-1:0] init_var;

  // Filter state and working registers
  logic [2:0]    state;
  logic          var_phase;
  logic [CW-1:0] cnt;
  logic [DW-1:0] est;
  logic [VW-1:0] var_cur;
  logic [DW-1:0] z;
  logic [VW-1:0] prior;
  logic [DW-1:0] den;
  logic [DW:0]   rem;
  logic [GW-1:0] gain;
  logic [DW:0]   diff;
  logic          neg;
  logic [DW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [AW-1:0] acc;

  // Result register
  logic          out_valid;
  logic [DW-1:0] res_est;
  logic [VW-1:0] res_var;
  logic [GW-1:0] res_gain;

  // Combinational helpers
  logic [DW-1:0]             prior_sum;
  logic [DW-1:0]             den_sum;
  logic [DW:0]               diff_w;
  logic                      q_bit;
  logic [DW:0]               rem_sub;
  logic [GW-1:0]             gain_sat;
  logic [DW:0]               mag_w;
  logic [DW+MUL_CHUNK_W-1:0] prod;
  logic [AW-1:0]             acc_next;
  logic [AW-1:0]             rnd_w;
  logic [DW-1:0]             rnd;
  logic [VW-1:0]             var_new;
  logic                      in_fire;
  logic                      out_free;
  logic                      res_load;

  assign in_fire  = meas.valid && meas.ready;
  assign out_free = !out_valid || result.ready;
  assign res_load = (state == S_MULV) && out_free;

  // Prior, denominator and innovation adders
  assign prior_sum = {1'b0, var_cur} + {1'b0, q_noise};
  assign den_sum   = {1'b0, prior} + {1'b0, r_noise};
  assign diff_w    = {z[DW-1], z} - {est[DW-1], est};

  // Restoring divider step, no quotient bits for a zero denominator
  assign q_bit   = (den != '0) && (rem >= {1'b0, den});
  assign rem_sub = q_bit ? (rem - {1'b0, den}) : rem;
  assign gain_sat = (gain > ONE_G) ? ONE_G : gain;
  assign mag_w   = diff[DW] ? (~diff + 1'b1) : diff;

  // Shared multiplier: one 16-bit slice of mul_b per cycle, top slice first
  assign prod     = mul_a * mul_b[BW-1 -: MUL_CHUNK_W];
  assign acc_next = (acc << MUL_CHUNK_W) + AW'(prod);

  // Round to nearest, ties away from zero (operands are magnitudes)
  assign rnd_w   = (acc + HALF) >> FRAC_BITS;
  assign rnd     = rnd_w[DW-1:0];
  assign var_new = rnd[DW-1] ? VAR_MAX : rnd[VW-1:0];

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_noise  <= VW'(PROCESS_NOISE_RST);
      r_noise  <= VW'(MEASUREMENT_NOISE_RST);
      init_est <= '0;
      init_var <= VW'(ONE_G);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_PROCESS_NOISE:     q_noise  <= cfg.data[VW-1:0];
        REG_MEASUREMENT_NOISE: r_noise  <= cfg.data[VW-1:0];
        REG_INITIAL_ESTIMATE:  init_est <= cfg.data;
        REG_INITIAL_VARIANCE:  init_var <= cfg.data[VW-1:0];
        default: ;
      endcase
    end
  end

  // Update sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      var_phase <= 1'b0;
      cnt       <= '0;
      est       <= '0;
      var_cur   <= VW'(ONE_G);
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready && !res_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            z <= meas.measurement;
            if (meas.restart) begin
              est     <= init_est;
              var_cur <= init_var;
            end
            state <= S_PRIOR;
          end
        end
        S_PRIOR: begin
          prior <= prior_sum[DW-1] ? VAR_MAX : prior_sum[VW-1:0];
          state <= S_DEN;
        end
        S_DEN: begin
          den   <= den_sum;
          rem   <= {2'b00, prior};
          diff  <= diff_w;
          gain  <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= {rem_sub[DW-1:0], 1'b0};
          gain <= {gain[GW-2:0], q_bit};
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(FRAC_BITS)) begin
            state <= S_GSAT;
          end
        end
        S_GSAT: begin
          gain      <= gain_sat;
          neg       <= diff[DW];
          mul_a     <= mag_w[DW-1:0];
          mul_b     <= BW'(gain_sat);
          acc       <= '0;
          cnt       <= '0;
          var_phase <= 1'b0;
          state     <= S_MULE;
        end
        S_MULE: begin
          acc   <= acc_next;
          mul_b <= mul_b << MUL_CHUNK_W;
          cnt   <= cnt + 1'b1;
          if (cnt == CW'(NCHUNK - 1)) begin
            state <= var_phase ? S_MULV : S_EST;
          end
        end
        S_EST: begin
          est       <= neg ? (est - rnd) : (est + rnd);
          mul_a     <= {1'b0, prior};
          mul_b     <= BW'(ONE_G - gain);
          acc       <= '0;
          cnt       <= '0;
          var_phase <= 1'b1;
          state     <= S_MULE;
        end
        S_MULV: begin
          // Variance product done: hand the result over once the output is free
          if (res_load) begin
            var_cur   <= var_new;
            res_est   <= est;
            res_var   <= var_new;
            res_gain  <= gain;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign meas.ready            = (state == S_IDLE);
  assign result.valid          = out_valid;
  assign result.estimate       = res_est;
  assign result.error_variance = res_var;
  assign result.gain           = res_gain;

  `ASSERT_SAME(a_gain_range, clk, rst, out_valid, res_gain <= ONE_G,
               "result gain above 1.0")
  `ASSERT_NEXT(a_accept_starts, clk, rst, in_fire, state == S_PRIOR,
               "measurement transaction did not start an update")
  `ASSERT_SAME(a_div_count, clk, rst, state == S_DIV, cnt <= CW'(FRAC_BITS),
               "divider ran past its last quotient bit")
  `ASSERT_NEXT(a_out_drain, clk, rst, out_valid && result.ready && !res_load,
               !out_valid, "result register not released after transaction")
  `ASSERT_SAME(a_mul_count, clk, rst, state == S_MULE, cnt <= CW'(NCHUNK - 1),
               "multiplier ran past its last slice")

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import skf_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;

  localparam longint unsigned VAR_MAX  = (64'd1 << (DW - 1)) - 1;
  localparam longint unsigned ONE_FX   = 64'd1 << FB;
  localparam longint unsigned HALF_LSB = 64'd1 << (FB - 1);

  // Result latency of the filter
  localparam int RESULT_LATENCY  = FB + 10;
  localparam int SETTLE_CYCLES   = 2 * RESULT_LATENCY;
  localparam int DRAIN_LIMIT     = 4000;
  localparam int RANDOM_PHASES   = 14;
  localparam int ITEMS_PER_PHASE = 100;

  typedef struct packed {
    logic [DW-1:0] estimate;
    logic [DW-2:0] error_variance;
    logic [FB:0]   gain;
  } update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  skf_meas_if meas_bus ();
  skf_res_if  res_bus ();
  skf_cfg_if  cfg_bus ();

  scalar_kalman_filter_unit dut (
    .clk    (clk),
    .rst    (rst),
    .meas   (meas_bus),
    .result (res_bus),
    .cfg    (cfg_bus)
  );

  always #10 clk = ~clk;

  // Shadow copy of the registers and of the filter state
  logic [DW-2:0]        proc_noise;
  logic [DW-2:0]        meas_noise;
  logic signed [DW-1:0] start_estimate;
  logic [DW-2:0]        start_variance;
  logic signed [DW-1:0] filt_estimate;
  logic [DW-2:0]        filt_variance;

  update_t     expected_updates[$];
  int unsigned fail_count = 0;
  bit          src_idle = 1'b0;
  bit          snk_idle = 1'b0;
  int unsigned stall_left;

  // One filter update: reload on restart, predict, gain, correct
  function automatic update_t kalman_update(logic signed [DW-1:0] z, logic restart);
    longint unsigned prior, den, gain, mag, corr, post;
    longint          diff, next_est;
    logic            neg;
    update_t         o;
    if (restart) begin
      filt_estimate = start_estimate;
      filt_variance = start_variance;
    end
    prior = filt_variance;
    prior += proc_noise;
    if (prior > VAR_MAX) prior = VAR_MAX;
    den = prior + meas_noise;
    // truncated quotient, same as a restoring divider
    gain = (den == 0) ? 64'd0 : (prior << FB) / den;
    if (gain > ONE_FX) gain = ONE_FX;
    // correction rounded on the magnitude: ties away from zero
    diff = longint'(z) - longint'(filt_estimate);
    neg  = diff < 0;
    mag  = neg ? -diff : diff;
    corr = (mag * gain + HALF_LSB) >> FB;
    next_est = neg ? longint'(filt_estimate) - longint'(corr)
                   : longint'(filt_estimate) + longint'(corr);
    filt_estimate = next_est[DW-1:0];
    post = (prior * (ONE_FX - gain) + HALF_LSB) >> FB;
    if (post > VAR_MAX) post = VAR_MAX;
    filt_variance = post[DW-2:0];
    o.estimate       = filt_estimate;
    o.error_variance = filt_variance;
    o.gain           = gain[FB:0];
    return o;
  endfunction

  // Send one measurement transaction and record its expected update
  task automatic send_measurement(logic [DW-1:0] z, logic restart);
    int unsigned gap;
    gap = src_idle ? $urandom_range(5, 0) : 0;
    if (gap != 0) begin
      meas_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    meas_bus.valid       <= 1'b1;
    meas_bus.measurement <= z;
    meas_bus.restart     <= restart;
    @(posedge clk);
    while (!meas_bus.ready) @(posedge clk);
    expected_updates.push_back(kalman_update(z, restart));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    meas_bus.valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [DW-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_PROCESS_NOISE:     proc_noise     = data[DW-2:0];
      REG_MEASUREMENT_NOISE: meas_noise     = data[DW-2:0];
      REG_INITIAL_ESTIMATE:  start_estimate = data;
      REG_INITIAL_VARIANCE:  start_variance = data[DW-2:0];
      default: ;
    endcase
  endtask

  // Write all four registers; only call while the filter is idle
  task automatic program_filter(logic [DW-1:0] q, logic [DW-1:0] r,
                                logic [DW-1:0] x0, logic [DW-1:0] p0);
    write_reg(REG_PROCESS_NOISE, q);
    write_reg(REG_MEASUREMENT_NOISE, r);
    write_reg(REG_INITIAL_ESTIMATE, x0);
    write_reg(REG_INITIAL_VARIANCE, p0);
    cfg_bus.valid <= 1'b0;
  endtask

  // Register value: extremes, full random, or a random magnitude
  function automatic logic [DW-1:0] pick_setting();
    case ($urandom_range(5, 0))
      0:       return $urandom_range(1, 0) ? 32'h8000_0000 : 32'h0000_0000;
      1:       return $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
      2:       return $urandom();
      default: return $urandom() >> $urandom_range(31, 3);
    endcase
  endfunction

  // Result side: random back-pressure and field checks
  always @(posedge clk) begin
    update_t     want;
    int unsigned n;
    if (rst) begin
      res_bus.ready <= 1'b0;
      stall_left    <= 0;
    end else if (res_bus.valid && res_bus.ready) begin
      if (expected_updates.size() == 0) begin
        $error("result transaction with nothing pending: estimate %h", res_bus.estimate);
        fail_count++;
      end else begin
        want = expected_updates.pop_front();
        if (res_bus.estimate !== want.estimate) begin
          $error("estimate: expected %h, got %h", want.estimate, res_bus.estimate);
          fail_count++;
        end
        if (res_bus.error_variance !== want.error_variance) begin
          $error("error_variance: expected %h, got %h",
                 want.error_variance, res_bus.error_variance);
          fail_count++;
        end
        if (res_bus.gain !== want.gain) begin
          $error("gain: expected %h, got %h", want.gain, res_bus.gain);
          fail_count++;
        end
      end
      n = snk_idle ? $urandom_range(5, 0) : 0;
      if (n != 0) begin
        res_bus.ready <= 1'b0;
        stall_left    <= n - 1;
      end
    end else if (!res_bus.ready) begin
      if (stall_left == 0) res_bus.ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  // Reset defaults, full-scale measurements, a restart
  task automatic test_default_setting();
    send_measurement(32'h1000_0000, 1'b0);
    send_measurement(32'h7FFF_FFFF, 1'b0);
    send_measurement(32'h8000_0000, 1'b0);
    send_measurement(32'h0000_0000, 1'b1);
    send_measurement(32'hF000_0000, 1'b0);
  endtask

  // All registers at maximum: prior saturates
  task automatic test_saturated_prior();
    drain_results();
    program_filter(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_measurement(32'h8000_0000, 1'b1);
    send_measurement(32'h7FFF_FFFF, 1'b0);
    send_measurement(32'h0000_0000, 1'b0);
  endtask

  // R = 0: unity gain, then variance hits zero and the denominator follows
  task automatic test_unity_gain();
    drain_results();
    program_filter(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001);
    send_measurement(32'h7FFF_FFFF, 1'b1);
    send_measurement(32'h8000_0000, 1'b0);
    send_measurement(32'h0000_0005, 1'b0);
  endtask

  // Zero denominator straight after restart; top data bit must be dropped
  task automatic test_zero_denominator();
    drain_results();
    program_filter(32'h8000_0000, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000);
    send_measurement(32'h7FFF_FFFF, 1'b1);
    send_measurement(32'h8000_0000, 1'b0);
  endtask

  // New initial values only apply once a restart comes in
  task automatic test_deferred_reload();
    drain_results();
    program_filter(32'h0000_1000, 32'h0100_0000, 32'h3000_0000, 32'h0800_0000);
    send_measurement(32'h2000_0000, 1'b0);
    send_measurement(32'h2000_0000, 1'b1);
    send_measurement(32'hD000_0000, 1'b0);
  endtask

  // Gain of exactly one half: odd differences land on a rounding tie
  task automatic test_rounding_ties();
    drain_results();
    program_filter(32'h0000_0000, 32'h1000_0000, 32'h0000_0000, 32'h1000_0000);
    send_measurement(32'h0000_0001, 1'b1);
    send_measurement(32'hFFFF_FFFF, 1'b1);
    send_measurement(32'h0000_0003, 1'b1);
  endtask

  // Random settings, each followed by a noisy track of one value
  task automatic test_random_phases();
    logic [DW-1:0] target;
    logic [DW-1:0] z;
    int unsigned   spread;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      program_filter(pick_setting(), pick_setting(), pick_setting(), pick_setting());
      src_idle = ph[0];
      snk_idle = ph[1];
      target = $urandom();
      spread = $urandom_range(30, 2);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(7, 0) == 0) z = $urandom();
        else z = target + ($urandom() >> (32 - spread)) - (32'd1 << (spread - 1));
        send_measurement(z, (k == 0) ? 1'($urandom_range(1, 0))
                                     : ($urandom_range(15, 0) == 0));
      end
    end
  endtask

  initial begin
    meas_bus.valid       <= 1'b0;
    meas_bus.measurement <= '0;
    meas_bus.restart     <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= REG_PROCESS_NOISE;
    cfg_bus.data         <= '0;
    proc_noise     = (DW-1)'(PROCESS_NOISE_RST);
    meas_noise     = (DW-1)'(MEASUREMENT_NOISE_RST);
    start_estimate = '0;
    start_variance = ONE_FX[DW-2:0];
    filt_estimate  = start_estimate;
    filt_variance  = start_variance;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_default_setting();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    test_saturated_prior();
    test_unity_gain();
    test_zero_denominator();
    test_deferred_reload();
    test_rounding_ties();
    test_random_phases();

    // Wind down: bounded wait for outstanding results, then watch for strays
    meas_bus.valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && expected_updates.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_updates.size() != 0) begin
      $error("%0d expected results never arrived", expected_updates.size());
      fail_count++;
    end
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
